// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/mrid_pkg.sv =====
`default_nettype none
package mrid_pkg;
	localparam int NUM_REGS       = 8;
	localparam int CFG_IDX_BITS   = 3;
	localparam int DIGIT_BITS     = 8;
	localparam int CELL_STEPS     = 4;
	localparam int DEF_COMPONENTS = 8;
	localparam int DEF_RADIX_BITS = 8;
	localparam int DEF_INDEX_BITS = 32;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_RADIX_0 = 3'd0,
		REG_RADIX_1 = 3'd1,
		REG_RADIX_2 = 3'd2,
		REG_RADIX_3 = 3'd3,
		REG_RADIX_4 = 3'd4,
		REG_RADIX_5 = 3'd5,
		REG_RADIX_6 = 3'd6,
		REG_RADIX_7 = 3'd7
	} reg_idx_t;
endpackage
`default_nettype wire

// ===== sv/mrid_div_cell.sv =====
`default_nettype none
module mrid_div_cell import mrid_pkg::*; #(
	parameter int COMPONENTS = DEF_COMPONENTS,
	parameter int RADIX_BITS = DEF_RADIX_BITS,
	parameter int INDEX_BITS = DEF_INDEX_BITS,
	parameter int STEPS      = CELL_STEPS,
	parameter int COMP       = 1,
	parameter bit LAST       = 1'b0
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             adv,
	input  wire logic [RADIX_BITS-1:0]            divisor,
	input  wire logic                             valid_i,
	input  wire logic [INDEX_BITS-1:0]            work_i,
	input  wire logic [RADIX_BITS-1:0]            rem_i,
	input  wire logic [COMPONENTS*RADIX_BITS-1:0] dig_i,
	output logic                                  valid_o,
	output logic [INDEX_BITS-1:0]                 work_o,
	output logic [RADIX_BITS-1:0]                 rem_o,
	output logic [COMPONENTS*RADIX_BITS-1:0]      dig_o
);
	logic [INDEX_BITS-1:0]            work_d;
	logic [RADIX_BITS-1:0]            rem_d;
	logic [COMPONENTS*RADIX_BITS-1:0] dig_d;

	// Restoring division: shift one dividend bit into the remainder per step.
	always_comb begin
		logic [RADIX_BITS:0] t;
		work_d = work_i;
		rem_d  = rem_i;
		for (int s = 0; s < STEPS; s++) begin
			t      = {rem_d, work_d[INDEX_BITS-1]};
			work_d = {work_d[INDEX_BITS-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t         = t - {1'b0, divisor};
				work_d[0] = 1'b1;
			end
			rem_d = t[RADIX_BITS-1:0];
		end
		dig_d = dig_i;
		if (LAST) begin
			dig_d[COMP*RADIX_BITS +: RADIX_BITS] = rem_d;
			rem_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (adv) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			work_o <= work_d;
			rem_o  <= rem_d;
			dig_o  <= dig_d;
		end
	end
endmodule
`default_nettype wire

// ===== sv/mrid_check.sv =====
`default_nettype none
module mrid_check import mrid_pkg::*; #(
	parameter int COMPONENTS = DEF_COMPONENTS,
	parameter int RADIX_BITS = DEF_RADIX_BITS,
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             adv,
	input  wire logic [RADIX_BITS-1:0]            radix0,
	input  wire logic                             zero_radix,
	input  wire logic                             valid_i,
	input  wire logic [INDEX_BITS-1:0]            quot_i,
	input  wire logic [COMPONENTS*RADIX_BITS-1:0] dig_i,
	output logic                                  valid_q,
	output logic                                  oor_q,
	output logic [COMPONENTS*RADIX_BITS-1:0]      dig_q
);
	`include "assert_macros.svh"

	logic                             oor_d;
	logic [COMPONENTS*RADIX_BITS-1:0] dig_d;

	// The quotient left for the top component must fit below its radix.
	always_comb begin
		oor_d = zero_radix || (quot_i >= INDEX_BITS'(radix0));
		dig_d = dig_i;
		dig_d[RADIX_BITS-1:0] = quot_i[RADIX_BITS-1:0];
		if (oor_d) begin
			dig_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_q <= oor_d;
			dig_q <= dig_d;
		end
	end

	`ASSERT_SAME(a_oor_zero, clk, arst_n, valid_q && oor_q, dig_q == '0)
	`ASSERT_SAME(a_top_digit, clk, arst_n, valid_q && !oor_q, dig_q[RADIX_BITS-1:0] < radix0)
	`ASSERT_NEXT(a_hold, clk, arst_n, valid_q && !adv, valid_q && $stable(dig_q) && $stable(oor_q))
endmodule
`default_nettype wire

// ===== sv/mixed_radix_index_decode_core.sv =====
`default_nettype none
// Each index passes through the division cells and then the range-check output register.
// Throughput: one word per cycle while the output is not stalled; every cell of the division chain advances together.
// Each cell retires up to four quotient bits of one component's restoring division.
// Reset clears all valid bits and sets every radix register to 1.
module mixed_radix_index_decode_core import mrid_pkg::*; #(
	parameter int COMPONENTS = DEF_COMPONENTS,
	parameter int RADIX_BITS = DEF_RADIX_BITS,
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [INDEX_BITS-1:0]   param_index,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [DIGIT_BITS-1:0]        digit_0,
	output logic [DIGIT_BITS-1:0]        digit_1,
	output logic [DIGIT_BITS-1:0]        digit_2,
	output logic [DIGIT_BITS-1:0]        digit_3,
	output logic [DIGIT_BITS-1:0]        digit_4,
	output logic [DIGIT_BITS-1:0]        digit_5,
	output logic [DIGIT_BITS-1:0]        digit_6,
	output logic [DIGIT_BITS-1:0]        digit_7,
	output logic                         out_of_range,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [RADIX_BITS-1:0]   cfg_data
);
	// Cells per component division and total cells in the chain.
	localparam int CPC = (INDEX_BITS + CELL_STEPS - 1) / CELL_STEPS;
	localparam int NC  = (COMPONENTS - 1) * CPC;
	localparam int DW  = COMPONENTS * RADIX_BITS;

	logic [RADIX_BITS-1:0] radix_q [NUM_REGS];
	logic                  adv;
	logic                  zero_radix;
	logic                  out_oor;
	logic [DW-1:0]         out_dig;
	logic [DIGIT_BITS-1:0] digit_w [NUM_REGS];

	logic                  ch_valid [NC+1];
	logic [INDEX_BITS-1:0] ch_work  [NC+1];
	logic [RADIX_BITS-1:0] ch_rem   [NC+1];
	logic [DW-1:0]         ch_dig   [NC+1];

	// Configuration: always ready; the user must change radices only while the chain is empty; not enforced.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				radix_q[i] <= RADIX_BITS'(1);
			end
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_RADIX_0: radix_q[0] <= cfg_data;
				REG_RADIX_1: radix_q[1] <= cfg_data;
				REG_RADIX_2: radix_q[2] <= cfg_data;
				REG_RADIX_3: radix_q[3] <= cfg_data;
				REG_RADIX_4: radix_q[4] <= cfg_data;
				REG_RADIX_5: radix_q[5] <= cfg_data;
				REG_RADIX_6: radix_q[6] <= cfg_data;
				REG_RADIX_7: radix_q[7] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Any active zero radix empties the space: every word goes out of range.
	always_comb begin
		zero_radix = 1'b0;
		for (int i = 0; i < COMPONENTS; i++) begin
			if (radix_q[i] == '0) begin
				zero_radix = 1'b1;
			end
		end
	end

	// Hold the whole chain while the result word is stalled.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	assign ch_valid[0] = in_valid;
	assign ch_work[0]  = param_index;
	assign ch_rem[0]   = '0;
	assign ch_dig[0]   = '0;

	// Divide least significant component first; each cell hands work and remainder on.
	for (genvar k = 0; k < NC; k++) begin : g_cell
		localparam int COMP  = COMPONENTS - 1 - k / CPC;
		localparam int J     = k % CPC;
		localparam int STEPS = (J == CPC - 1) ? INDEX_BITS - J * CELL_STEPS : CELL_STEPS;

		mrid_div_cell #(
			.COMPONENTS (COMPONENTS),
			.RADIX_BITS (RADIX_BITS),
			.INDEX_BITS (INDEX_BITS),
			.STEPS      (STEPS),
			.COMP       (COMP),
			.LAST       (J == CPC - 1)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.divisor (radix_q[COMP]),
			.valid_i (ch_valid[k]),
			.work_i  (ch_work[k]),
			.rem_i   (ch_rem[k]),
			.dig_i   (ch_dig[k]),
			.valid_o (ch_valid[k+1]),
			.work_o  (ch_work[k+1]),
			.rem_o   (ch_rem[k+1]),
			.dig_o   (ch_dig[k+1])
		);
	end

	// Final stage: range test against the top radix, doubles as the output register.
	mrid_check #(
		.COMPONENTS (COMPONENTS),
		.RADIX_BITS (RADIX_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.radix0     (radix_q[0]),
		.zero_radix (zero_radix),
		.valid_i    (ch_valid[NC]),
		.quot_i     (ch_work[NC]),
		.dig_i      (ch_dig[NC]),
		.valid_q    (out_valid),
		.oor_q      (out_oor),
		.dig_q      (out_dig)
	);

	// Map digits to fixed-width ports; inactive components read zero.
	for (genvar i = 0; i < NUM_REGS; i++) begin : g_dig
		if (i < COMPONENTS) begin : g_on
			if (RADIX_BITS >= DIGIT_BITS) begin : g_trunc
				assign digit_w[i] = out_dig[i*RADIX_BITS +: DIGIT_BITS];
			end else begin : g_ext
				assign digit_w[i] = {{(DIGIT_BITS-RADIX_BITS){1'b0}},
					out_dig[i*RADIX_BITS +: RADIX_BITS]};
			end
		end else begin : g_off
			assign digit_w[i] = '0;
		end
	end

	assign digit_0      = digit_w[0];
	assign digit_1      = digit_w[1];
	assign digit_2      = digit_w[2];
	assign digit_3      = digit_w[3];
	assign digit_4      = digit_w[4];
	assign digit_5      = digit_w[5];
	assign digit_6      = digit_w[6];
	assign digit_7      = digit_w[7];
	assign out_of_range = out_oor;
endmodule
`default_nettype wire

// ===== tb/tb_mixed_radix_index_decode_core.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_mixed_radix_index_decode_core;
	import mrid_pkg::*;

	localparam int LATENCY = 57;

	typedef struct packed {
		logic [7:0][DIGIT_BITS-1:0] digits;
		logic                       oor;
	} decode_word_t;

	// Expected decodes, oldest first, plus a private copy of the radices.
	class decode_board;
		logic [DEF_RADIX_BITS-1:0] radix[NUM_REGS];
		decode_word_t pending[$];
		int errors;
		int checked;

		function new();
			for (int i = 0; i < NUM_REGS; i++) radix[i] = DEF_RADIX_BITS'(1);
			errors = 0;
			checked = 0;
		endfunction

		// Split the index, least significant component first.
		function void note_index(logic [DEF_INDEX_BITS-1:0] idx);
			decode_word_t w;
			logic [DEF_INDEX_BITS-1:0] rest;
			w = '0;
			rest = idx;
			for (int i = 0; i < NUM_REGS; i++)
				if (radix[i] == 0) w.oor = 1'b1;
			if (!w.oor) begin
				for (int i = NUM_REGS - 1; i > 0; i--) begin
					w.digits[i] = DIGIT_BITS'(rest % radix[i]);
					rest = rest / radix[i];
				end
				if (rest >= radix[0]) w.oor = 1'b1;
				else w.digits[0] = DIGIT_BITS'(rest);
			end
			if (w.oor) w.digits = '0;
			pending.push_back(w);
		endfunction

		function void check_word(decode_word_t act);
			decode_word_t exp;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected output word");
				errors++;
				return;
			end
			exp = pending.pop_front();
			for (int i = 0; i < NUM_REGS; i++)
				if (act.digits[i] !== exp.digits[i]) begin
					$error("digit_%0d expected %0d actual %0d", i, exp.digits[i],
						act.digits[i]);
					errors++;
				end
			if (act.oor !== exp.oor) begin
				$error("out_of_range expected %0d actual %0d", exp.oor, act.oor);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [DEF_INDEX_BITS-1:0] param_index = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [DIGIT_BITS-1:0] digit_0, digit_1, digit_2, digit_3;
	logic [DIGIT_BITS-1:0] digit_4, digit_5, digit_6, digit_7;
	logic out_of_range;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [DEF_RADIX_BITS-1:0] cfg_data = '0;

	// Idle and stall percentages for the current phase.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int words_sent = 0;
	int oor_seen = 0;
	decode_board board;

	mixed_radix_index_decode_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .param_index(param_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.digit_0(digit_0), .digit_1(digit_1), .digit_2(digit_2), .digit_3(digit_3),
		.digit_4(digit_4), .digit_5(digit_5), .digit_6(digit_6), .digit_7(digit_7),
		.out_of_range(out_of_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Drive the receiver stall at random and check each accepted word.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_word({{digit_7, digit_6, digit_5, digit_4,
				digit_3, digit_2, digit_1, digit_0}, out_of_range});
			if (out_of_range) oor_seen++;
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Write one radix register; the block is idle whenever this is called.
	task automatic write_radix(reg_idx_t idx, logic [DEF_RADIX_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.radix[idx] = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Send one index word, with a random gap in front of it; valid stays up
	// after the handshake so that words can follow back to back.
	task automatic send_index(logic [DEF_INDEX_BITS-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		param_index <= idx;
		do @(posedge clk); while (in_stall);
		board.note_index(idx);
		words_sent++;
	endtask

	// Drop valid and let the pipeline drain before touching the radices.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Size of the current space, saturated to 33 bits.
	function automatic longint space_size();
		longint s;
		s = 1;
		for (int i = 0; i < NUM_REGS; i++) begin
			s = s * board.radix[i];
			if (s > 64'h1_0000_0000) s = 64'h1_0000_0000;
		end
		return s;
	endfunction

	// Pick an index: mostly inside the space, some at the edge, some noise.
	function automatic logic [DEF_INDEX_BITS-1:0] pick_index();
		longint s;
		int sel;
		s = space_size();
		sel = $urandom_range(99);
		if (s == 0 || sel < 15) return $urandom();
		if (sel < 25) return DEF_INDEX_BITS'(s - 1 + $urandom_range(2));
		if (s > 64'hFFFF_FFFF) return $urandom();
		return DEF_INDEX_BITS'(({$urandom(), $urandom()} % s));
	endfunction

	task automatic program_radices(int mode);
		for (int i = 0; i < NUM_REGS; i++) begin
			case (mode)
				0: write_radix(reg_idx_t'(i), 8'd255);
				1: write_radix(reg_idx_t'(i), 8'(($urandom_range(3) == 0) ?
					$urandom_range(255) : $urandom_range(1, 16)));
				2: write_radix(reg_idx_t'(i), 8'((i < 4) ? 1 : $urandom_range(2, 255)));
				default: write_radix(reg_idx_t'(i), 8'($urandom_range(1, 255)));
			endcase
		end
	endtask

	initial begin
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset radices of 1, then radices of 255, a zero radix and radices of 2.
		send_index('0);
		send_index(32'd1);
		send_index('1);
		drain();
		write_radix(REG_RADIX_7, 8'd255);
		send_index(32'd254);
		send_index(32'd255);
		drain();
		program_radices(0);
		send_index('0);
		send_index('1);
		send_index(32'h8000_0000);
		send_index(32'h7FFF_FFFF);
		send_index(32'h5555_AAAA);
		drain();
		// Zero radix: every index is out of range.
		write_radix(REG_RADIX_3, 8'd0);
		send_index('0);
		send_index(32'd12345);
		drain();
		for (int i = 0; i < NUM_REGS; i++) write_radix(reg_idx_t'(i), 8'd2);
		send_index(32'd0);
		send_index(32'd170);
		send_index(32'd255);
		send_index(32'd256);
		drain();

		// Random phases over the four idling profiles.
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			program_radices(ph % 4);
			repeat (108) send_index(pick_index());
			drain();
		end

		$display("sent %0d index words over 21 radix settings, %0d out of range",
			words_sent, oor_seen);
		$display("checked %0d output words with all four idling profiles", board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
